/* sv/rbec_pkg.sv */
// rbec_pkg: shared widths, latencies, face codes and types of the ray box entry clip.
// Used by every module of the block; depends on nothing.
package rbec_pkg;

  localparam int FRACTION_BITS = 32;
  localparam int CW = 64;
  localparam int XW = CW + 2;
  localparam int MW = CW + 1;
  localparam int QW = 32;
  localparam int PW = MW + QW;
  localparam int HW = MW - QW + QW;
  localparam int AXES = 3;

  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = QW / DIV_STEPS;
  localparam int SCALE_LAT = 3;
  localparam int SEL_LAT = 2;
  localparam int TOTAL_LAT = 1 + DIV_STAGES + SCALE_LAT + SEL_LAT;

  localparam logic [31:0] EPS_RESET =
    32'(((64'd1 << FRACTION_BITS) + 64'd5000000) / 64'd10000000);

  localparam int AW = 3;
  localparam logic REG_EPSILON = 1'b0;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [2:0] FACE_WEST  = 3'd0;
  localparam logic [2:0] FACE_EAST  = 3'd1;
  localparam logic [2:0] FACE_DOWN  = 3'd2;
  localparam logic [2:0] FACE_UP    = 3'd3;
  localparam logic [2:0] FACE_NORTH = 3'd4;
  localparam logic [2:0] FACE_SOUTH = 3'd5;

  typedef logic signed [XW-1:0] wide_t;
  typedef logic [MW-1:0] mag_t;
  typedef logic [QW-1:0] frac_t;

  typedef struct packed {
    logic cand;
    logic up;
    mag_t num;
    mag_t den;
  } axis_t;

  typedef struct packed {
    wide_t st;
    wide_t d;
  } ray_t;

  typedef struct packed {
    wide_t mn;
    wide_t mx;
  } span_t;

  function automatic logic [2:0] face_code(input logic [1:0] axis, input logic up);
    logic [2:0] f;
    unique case (axis)
      AXIS_X:  f = up ? FACE_WEST : FACE_EAST;
      AXIS_Y:  f = up ? FACE_DOWN : FACE_UP;
      AXIS_Z:  f = up ? FACE_NORTH : FACE_SOUTH;
      default: f = FACE_WEST;
    endcase
    return f;
  endfunction

endpackage

/* sv/ray_box_entry_clip.sv */
// ray_box_entry_clip: top level; configuration register, delay lines and the pipeline.
// Depends on rbec_pkg, rbec_front, rbec_div, rbec_scale and rbec_select.
//
// Usage:
//   Raise start with one box (min/max per axis) and one segment (start/end point),
//   all signed Q32.32. The request is taken at every clock edge with start high and
//   busy low; busy stays low, so one request enters per clock cycle.
//   Each request gives exactly one result from the last pipeline stage, shown
//   for one cycle with done high: hit_found, entry_face, hit_fraction (Q0.32) and
//   hit_x/y/z. With no hit all result fields are zero.
//   The pipeline holds 16 divider stages (two quotient bits each) for the entry
//   fraction, plus one input stage, three multiply stages and two selection stages.
//   Results leave in request order; the receiver cannot stall the block.
//   epsilon sits at APB address 0 and resets to 429 (about 1e-7); write it only
//   while no request is in flight.
//   Reset empties the pipeline: no done pulse follows a request taken before reset.
module ray_box_entry_clip (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [63:0]   box_min_x,
  input  logic signed [63:0]   box_min_y,
  input  logic signed [63:0]   box_min_z,
  input  logic signed [63:0]   box_max_x,
  input  logic signed [63:0]   box_max_y,
  input  logic signed [63:0]   box_max_z,
  input  logic signed [63:0]   ray_start_x,
  input  logic signed [63:0]   ray_start_y,
  input  logic signed [63:0]   ray_start_z,
  input  logic signed [63:0]   ray_end_x,
  input  logic signed [63:0]   ray_end_y,
  input  logic signed [63:0]   ray_end_z,
  output logic                 done,
  output logic                 hit_found,
  output logic [2:0]           entry_face,
  output logic [31:0]          hit_fraction,
  output logic signed [63:0]   hit_x,
  output logic signed [63:0]   hit_y,
  output logic signed [63:0]   hit_z,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rbec_pkg::*;

  localparam int RAY_DLY = DIV_STAGES;
  localparam int BOX_DLY = DIV_STAGES + SCALE_LAT;

  logic [31:0] epsilon;
  wide_t [2:0] mn_w;
  wide_t [2:0] mx_w;
  wide_t [2:0] st_w;
  wide_t [2:0] en_w;
  logic vld_f;
  axis_t [2:0] axis_f;
  ray_t [2:0] ray_f;
  span_t [2:0] span_f;
  logic vld_d [BOX_DLY];
  ray_t [2:0] ray_d [RAY_DLY];
  span_t [2:0] span_d [BOX_DLY];
  frac_t [2:0] t_div;
  logic [2:0] ok_div;
  logic [2:0] up_div;
  frac_t [2:0] t_d [SCALE_LAT];
  logic [2:0] ok_d [SCALE_LAT];
  logic [2:0] up_d [SCALE_LAT];
  wide_t [2:0][2:0] h;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EPSILON) ? epsilon : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EPSILON) begin
      epsilon <= pwdata;
    end
  end

  assign mn_w = {XW'(box_min_z), XW'(box_min_y), XW'(box_min_x)};
  assign mx_w = {XW'(box_max_z), XW'(box_max_y), XW'(box_max_x)};
  assign st_w = {XW'(ray_start_z), XW'(ray_start_y), XW'(ray_start_x)};
  assign en_w = {XW'(ray_end_z), XW'(ray_end_y), XW'(ray_end_x)};

  rbec_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (start && !busy),
    .epsilon (epsilon),
    .mn      (mn_w),
    .mx      (mx_w),
    .st      (st_w),
    .en      (en_w),
    .vld     (vld_f),
    .axis    (axis_f),
    .ray     (ray_f),
    .span    (span_f)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BOX_DLY; i++) begin
        vld_d[i] <= 1'b0;
      end
    end else begin
      vld_d[0] <= vld_f;
      for (int i = 1; i < BOX_DLY; i++) begin
        vld_d[i] <= vld_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ray_d[0] <= ray_f;
    for (int i = 1; i < RAY_DLY; i++) begin
      ray_d[i] <= ray_d[i-1];
    end
    span_d[0] <= span_f;
    for (int i = 1; i < BOX_DLY; i++) begin
      span_d[i] <= span_d[i-1];
    end
    t_d[0] <= t_div;
    ok_d[0] <= ok_div;
    up_d[0] <= up_div;
    for (int i = 1; i < SCALE_LAT; i++) begin
      t_d[i] <= t_d[i-1];
      ok_d[i] <= ok_d[i-1];
      up_d[i] <= up_d[i-1];
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    rbec_div u_div (
      .clk (clk),
      .in  (axis_f[a]),
      .q   (t_div[a]),
      .ok  (ok_div[a]),
      .up  (up_div[a])
    );
    for (genvar b = 0; b < AXES; b++) begin : g_coord
      rbec_scale u_scale (
        .clk  (clk),
        .d    (ray_d[RAY_DLY-1][b].d),
        .t    (t_div[a]),
        .base (ray_d[RAY_DLY-1][b].st),
        .h    (h[a][b])
      );
    end
  end

  rbec_select u_select (
    .clk          (clk),
    .rst          (rst),
    .vld_in       (vld_d[BOX_DLY-1]),
    .epsilon      (epsilon),
    .span         (span_d[BOX_DLY-1]),
    .h            (h),
    .t            (t_d[SCALE_LAT-1]),
    .ok           (ok_d[SCALE_LAT-1]),
    .up           (up_d[SCALE_LAT-1]),
    .done         (done),
    .hit_found    (hit_found),
    .entry_face   (entry_face),
    .hit_fraction (hit_fraction),
    .hit_x        (hit_x),
    .hit_y        (hit_y),
    .hit_z        (hit_z)
  );

endmodule

/* sv/rbec_front.sv */
// rbec_front: first stage; forms deltas, picks entry planes and flags candidate axes.
// Depends on rbec_pkg.
module rbec_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req,
  input  logic [31:0]               epsilon,
  input  rbec_pkg::wide_t [2:0]     mn,
  input  rbec_pkg::wide_t [2:0]     mx,
  input  rbec_pkg::wide_t [2:0]     st,
  input  rbec_pkg::wide_t [2:0]     en,
  output logic                      vld,
  output rbec_pkg::axis_t [2:0]     axis,
  output rbec_pkg::ray_t [2:0]      ray,
  output rbec_pkg::span_t [2:0]     span
);
  import rbec_pkg::*;

  wide_t eps_w;
  wide_t neg_eps;
  wide_t d_c [AXES];
  wide_t pl_c [AXES];
  mag_t ap_c [AXES];
  mag_t ad_c [AXES];
  logic up_c [AXES];
  logic dn_c [AXES];
  logic cand_c [AXES];

  assign eps_w = wide_t'({{(XW-32){1'b0}}, epsilon});
  assign neg_eps = -eps_w;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      d_c[a] = en[a] - st[a];
      up_c[a] = eps_w < d_c[a];
      dn_c[a] = d_c[a] < neg_eps;
      pl_c[a] = (up_c[a] ? mn[a] : mx[a]) - st[a];
      ap_c[a] = pl_c[a][XW-1] ? MW'(-pl_c[a]) : MW'(pl_c[a]);
      ad_c[a] = d_c[a][XW-1] ? MW'(-d_c[a]) : MW'(d_c[a]);
      cand_c[a] = (up_c[a] || dn_c[a]) && (pl_c[a] != '0) &&
                  (pl_c[a][XW-1] == d_c[a][XW-1]) && (ap_c[a] < ad_c[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= req;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      axis[a] <= '{cand: cand_c[a], up: up_c[a], num: ap_c[a], den: ad_c[a]};
      ray[a]  <= '{st: st[a], d: d_c[a]};
      span[a] <= '{mn: mn[a], mx: mx[a]};
    end
  end

endmodule

/* sv/rbec_div.sv */
// rbec_div: pipelined restoring divider giving floor(num * 2^32 / den) for num < den.
// Depends on rbec_pkg.
module rbec_div (
  input  logic                clk,
  input  rbec_pkg::axis_t     in,
  output rbec_pkg::frac_t     q,
  output logic                ok,
  output logic                up
);
  import rbec_pkg::*;

  typedef struct packed {
    mag_t  rem;
    frac_t q;
  } div_t;

  div_t  st_r   [DIV_STAGES];
  mag_t  den_r  [DIV_STAGES];
  logic  cand_r [DIV_STAGES];
  logic  up_r   [DIV_STAGES];

  function automatic div_t div_steps(input mag_t rem, input mag_t den, input frac_t qin);
    logic [MW:0] r;
    mag_t rr;
    frac_t qq;
    div_t o;
    rr = rem;
    qq = qin;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {rr, 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        qq = {qq[QW-2:0], 1'b1};
      end else begin
        qq = {qq[QW-2:0], 1'b0};
      end
      rr = r[MW-1:0];
    end
    o.rem = rr;
    o.q = qq;
    return o;
  endfunction

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_t src;
    mag_t den_in;
    logic cand_in;
    logic up_in;
    if (s == 0) begin : g_first
      assign src = '{rem: in.num, q: '0};
      assign den_in = in.den;
      assign cand_in = in.cand;
      assign up_in = in.up;
    end else begin : g_next
      assign src = st_r[s-1];
      assign den_in = den_r[s-1];
      assign cand_in = cand_r[s-1];
      assign up_in = up_r[s-1];
    end
    always_ff @(posedge clk) begin
      st_r[s]   <= div_steps(src.rem, den_in, src.q);
      den_r[s]  <= den_in;
      cand_r[s] <= cand_in;
      up_r[s]   <= up_in;
    end
  end

  assign q  = st_r[DIV_STAGES-1].q;
  assign ok = cand_r[DIV_STAGES-1] && (st_r[DIV_STAGES-1].q != '0);
  assign up = up_r[DIV_STAGES-1];

endmodule

/* sv/rbec_scale.sv */
// rbec_scale: pipelined base + floor(d * t / 2^32) with split partial products.
// Depends on rbec_pkg.
module rbec_scale (
  input  logic             clk,
  input  rbec_pkg::wide_t  d,
  input  rbec_pkg::frac_t  t,
  input  rbec_pkg::wide_t  base,
  output rbec_pkg::wide_t  h
);
  import rbec_pkg::*;

  mag_t m;
  logic neg1;
  logic neg2;
  logic [63:0] lo1;
  logic [HW-1:0] hi1;
  logic [PW-1:0] p2;
  wide_t base1;
  wide_t base2;
  logic signed [PW:0] sp;

  assign m = d[XW-1] ? MW'(-d) : MW'(d);

  always_ff @(posedge clk) begin
    neg1  <= d[XW-1];
    lo1   <= 64'(m[31:0]) * 64'(t);
    hi1   <= HW'(m[MW-1:32]) * HW'(t);
    base1 <= base;
  end

  always_ff @(posedge clk) begin
    neg2  <= neg1;
    p2    <= {hi1, 32'b0} + PW'(lo1);
    base2 <= base1;
  end

  assign sp = neg2 ? -$signed({1'b0, p2}) : $signed({1'b0, p2});

  always_ff @(posedge clk) begin
    h <= base2 + wide_t'(sp[PW:QW]);
  end

endmodule

/* sv/rbec_select.sv */
// rbec_select: bound checks of each candidate and choice of the entry face.
// Depends on rbec_pkg.
module rbec_select (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vld_in,
  input  logic [31:0]                 epsilon,
  input  rbec_pkg::span_t [2:0]       span,
  input  rbec_pkg::wide_t [2:0][2:0]  h,
  input  rbec_pkg::frac_t [2:0]       t,
  input  logic [2:0]                  ok,
  input  logic [2:0]                  up,
  output logic                        done,
  output logic                        hit_found,
  output logic [2:0]                  entry_face,
  output logic [31:0]                 hit_fraction,
  output logic signed [63:0]          hit_x,
  output logic signed [63:0]          hit_y,
  output logic signed [63:0]          hit_z
);
  import rbec_pkg::*;

  wide_t eps_w;
  wide_t lo_b [AXES];
  wide_t hi_b [AXES];
  logic [2:0] acc;
  logic vld_c;
  logic [2:0] acc_c;
  frac_t t_c [AXES];
  wide_t h_c [AXES][AXES];
  logic [2:0] up_c;
  logic [QW:0] best;
  logic [1:0] sel;
  logic found;

  assign eps_w = wide_t'({{(XW-32){1'b0}}, epsilon});

  always_comb begin
    for (int b = 0; b < AXES; b++) begin
      lo_b[b] = span[b].mn - eps_w;
      hi_b[b] = span[b].mx + eps_w;
    end
    for (int a = 0; a < AXES; a++) begin
      acc[a] = ok[a];
      for (int b = 0; b < AXES; b++) begin
        if (b != a && !(lo_b[b] < h[a][b] && h[a][b] < hi_b[b])) begin
          acc[a] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else begin
      vld_c <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    acc_c <= acc;
    up_c <= up;
    for (int a = 0; a < AXES; a++) begin
      t_c[a] <= t[a];
      for (int b = 0; b < AXES; b++) begin
        h_c[a][b] <= h[a][b];
      end
    end
  end

  always_comb begin
    best = {1'b1, {QW{1'b0}}};
    sel = AXIS_X;
    found = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (acc_c[a] && ({1'b0, t_c[a]} < best)) begin
        best = {1'b0, t_c[a]};
        sel = 2'(a);
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    hit_found    <= found;
    entry_face   <= found ? face_code(sel, up_c[sel]) : FACE_WEST;
    hit_fraction <= found ? t_c[sel] : '0;
    hit_x        <= found ? h_c[sel][0][CW-1:0] : '0;
    hit_y        <= found ? h_c[sel][1][CW-1:0] : '0;
    hit_z        <= found ? h_c[sel][2][CW-1:0] : '0;
  end

endmodule

/* sv/rbec_check.sv */
// rbec_check: port-level assertions for ray_box_entry_clip, attached by bind.
// Depends on rbec_pkg and ray_box_entry_clip.
module rbec_check (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic                hit_found,
  input logic [2:0]          entry_face,
  input logic [31:0]         hit_fraction,
  input logic signed [63:0]  hit_x,
  input logic signed [63:0]  hit_y,
  input logic signed [63:0]  hit_z
);
  import rbec_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("result missing after request");

  a_result_caused: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without request");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit_found) |-> (entry_face == FACE_WEST && hit_fraction == '0 &&
                              hit_x == '0 && hit_y == '0 && hit_z == '0))
    else $error("miss result not cleared");

  a_hit_sane: assert property (@(posedge clk) disable iff (rst)
    (done && hit_found) |-> (hit_fraction != '0 && entry_face <= FACE_SOUTH))
    else $error("hit result out of range");

endmodule

bind ray_box_entry_clip rbec_check u_check (.*);
